// ===== rtl/double_ended_queue_defines.svh =====
// Assertion macros used by the double-ended queue top level.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

`ifndef SYNTH

`define DEQ_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("deque assertion failed");

`define DEQ_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`else

`define DEQ_ASSERT_IMP(label, clk, rstn, ante, cons)

`define DEQ_ASSERT_NXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/deq_pkg.sv =====
// Operation codes, status codes and control structures of the double-ended queue.
package deq_pkg;

    localparam logic [2:0] MODE_PUSH_BACK  = 3'd0;
    localparam logic [2:0] MODE_POP_BACK   = 3'd1;
    localparam logic [2:0] MODE_LIST       = 3'd2;
    localparam logic [2:0] MODE_PUSH_FRONT = 3'd3;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic       push_back;
        logic       push_front;
        logic       pop_back;
        logic       pop_front;
        logic       list_start;
        logic       list_next;
        logic       load_const;
        logic       load_mem;
        logic [1:0] status;
        logic       last;
    } deq_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic list_last;
    } deq_sts_t;

endpackage

// ===== rtl/deq_dp.sv =====
// Datapath of the double-ended queue: ring buffer memory, pointers and result register.
module deq_dp #(
    parameter int CAPACITY = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  deq_pkg::deq_cmd_t cmd,
    input  logic [31:0]       in_value,
    output deq_pkg::deq_sts_t sts,
    output logic [31:0]       out_value,
    output logic [1:0]        out_status,
    output logic              out_last
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = IDX_W + 1;

    function automatic logic [IDX_W-1:0] wrap(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] d;
        d = s - SUM_W'(CAPACITY);
        if (s >= SUM_W'(CAPACITY)) begin
            return d[IDX_W-1:0];
        end
        return s[IDX_W-1:0];
    endfunction

    logic [31:0]      mem [CAPACITY];
    logic [31:0]      rd_data_reg;
    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [31:0]      out_value_reg;
    logic [1:0]       out_status_reg;
    logic             out_last_reg;

    logic [SUM_W-1:0] front_ext;
    logic [SUM_W-1:0] count_ext;
    logic [IDX_W-1:0] front_dec;
    logic [IDX_W-1:0] front_inc;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic             rd_en;

    assign front_ext = {1'b0, front_reg};
    assign count_ext = SUM_W'(count_reg);
    assign front_dec = (front_reg == '0) ? IDX_W'(CAPACITY - 1) : front_reg - IDX_W'(1);
    assign front_inc = (front_reg == IDX_W'(CAPACITY - 1)) ? '0 : front_reg + IDX_W'(1);

    assign wr_en = cmd.push_back | cmd.push_front;
    assign rd_en = cmd.pop_back | cmd.pop_front | cmd.list_start | cmd.list_next;

    always_comb begin
        front_next = front_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        wr_addr    = wrap(front_ext + count_ext);
        rd_addr    = front_reg;
        if (cmd.push_back) begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.push_front) begin
            wr_addr    = front_dec;
            front_next = front_dec;
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.pop_back) begin
            rd_addr    = wrap(front_ext + count_ext - SUM_W'(1));
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.pop_front) begin
            front_next = front_inc;
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.list_start) begin
            idx_next = '0;
        end
        if (cmd.list_next) begin
            rd_addr  = wrap(front_ext + SUM_W'(idx_reg) + SUM_W'(1));
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
        end else begin
            front_reg <= front_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= in_value;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_const) begin
            out_value_reg  <= '0;
            out_status_reg <= cmd.status;
            out_last_reg   <= 1'b1;
        end else if (cmd.load_mem) begin
            out_value_reg  <= rd_data_reg;
            out_status_reg <= deq_pkg::ST_OK;
            out_last_reg   <= cmd.last;
        end
    end

    assign sts.empty     = (count_reg == '0);
    assign sts.full      = (count_reg == CNT_W'(CAPACITY));
    assign sts.list_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule

// ===== rtl/deq_ctrl.sv =====
// Controller state machine of the double-ended queue.
module deq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        mode,
    output logic              out_valid,
    input  logic              out_ready,
    input  deq_pkg::deq_sts_t sts,
    output deq_pkg::deq_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       list_mode_reg, list_mode_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb begin
        state_next     = state_reg;
        list_mode_next = list_mode_reg;
        cmd            = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    list_mode_next = 1'b0;
                    case (mode)
                        deq_pkg::MODE_PUSH_BACK, deq_pkg::MODE_PUSH_FRONT: begin
                            cmd.load_const = 1'b1;
                            if (sts.full) begin
                                cmd.status = deq_pkg::ST_FULL;
                            end else begin
                                cmd.status     = deq_pkg::ST_OK;
                                cmd.push_back  = (mode == deq_pkg::MODE_PUSH_BACK);
                                cmd.push_front = (mode == deq_pkg::MODE_PUSH_FRONT);
                            end
                            state_next = S_OUT;
                        end
                        deq_pkg::MODE_POP_BACK, deq_pkg::MODE_POP_FRONT: begin
                            if (sts.empty) begin
                                cmd.load_const = 1'b1;
                                cmd.status     = deq_pkg::ST_EMPTY;
                                state_next     = S_OUT;
                            end else begin
                                cmd.pop_back   = (mode == deq_pkg::MODE_POP_BACK);
                                cmd.pop_front  = (mode == deq_pkg::MODE_POP_FRONT);
                                list_mode_next = 1'b0;
                                state_next     = S_READ;
                            end
                        end
                        deq_pkg::MODE_LIST: begin
                            if (sts.empty) begin
                                cmd.load_const = 1'b1;
                                cmd.status     = deq_pkg::ST_EMPTY;
                                state_next     = S_OUT;
                            end else begin
                                cmd.list_start = 1'b1;
                                list_mode_next = 1'b1;
                                state_next     = S_READ;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ: begin
                cmd.load_mem = 1'b1;
                cmd.last     = !list_mode_reg || sts.list_last;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (out_ready) begin
                    if (list_mode_reg && !sts.list_last) begin
                        cmd.list_next = 1'b1;
                        state_next    = S_READ;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            list_mode_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            list_mode_reg <= list_mode_next;
        end
    end

endmodule

// ===== rtl/double_ended_queue.sv =====
// Top level of the bounded double-ended queue of signed 32-bit values.
//
// The input stream carries one operation per word: push back, pop back,
// list, push front or pop front, with the value to push. The output stream
// returns one word per push or pop, with the popped value and a status in
// tuser; a listing returns every stored value from front to back, with
// tlast set on the final word. Status codes are ok, empty and full.
// Each word is handled alone: the input is ready only when no result is
// pending. A push result is valid in the cycle after acceptance; a popped
// or first listed value passes the registered ring buffer read and then
// the result register. A listing reads its stored values one at a time,
// each only after the previous one is taken. Undefined operation codes are
// taken and give no result.
// Reset empties the queue at once; no clearing pass runs. When the receiver
// stalls, the result word holds and no further input word is taken.
`include "double_ended_queue_defines.svh"

module double_ended_queue #(
    parameter int CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // mode [2:0], value [34:3], zero fill [39:35]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // value_res [31:0]
    output logic [1:0]  m_tuser,   // status [1:0]
    output logic        m_tlast
);

    deq_pkg::deq_cmd_t cmd;
    deq_pkg::deq_sts_t sts;

    deq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .mode      (s_tdata[2:0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    deq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_value   (s_tdata[34:3]),
        .sts        (sts),
        .out_value  (m_tdata),
        .out_status (m_tuser),
        .out_last   (m_tlast)
    );

    `DEQ_ASSERT_IMP(a_one_at_a_time, aclk, aresetn, m_tvalid, !s_tready)
    `DEQ_ASSERT_IMP(a_error_is_final, aclk, aresetn, m_tvalid && (m_tuser != deq_pkg::ST_OK), m_tlast && (m_tdata == '0))
    `DEQ_ASSERT_NXT(a_push_answers, aclk, aresetn, s_tvalid && s_tready && ((s_tdata[2:0] == deq_pkg::MODE_PUSH_BACK) || (s_tdata[2:0] == deq_pkg::MODE_PUSH_FRONT)), m_tvalid && m_tlast)

endmodule

// ===== tb/deque_checker.sv =====
// Checker for the double-ended queue: tracks the queue contents and compares every result word.
module deque_checker #(
    parameter int CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          error_count,
    output int          pending,
    output int          words_in,
    output int          results_out,
    output int          full_drops,
    output int          empty_reports
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
        logic        last;
    } deq_word_t;

    logic [31:0] deque_mem [CAPACITY];
    int unsigned front_pos;
    int unsigned depth_used;
    deq_word_t   owed_results[$];
    int          errs;
    int          n_in;
    int          n_out;
    int          n_full;
    int          n_empty;

    function automatic int unsigned slot(input int unsigned off);
        return (front_pos + off) % CAPACITY;
    endfunction

    task automatic owe(input logic [31:0] v, input logic [1:0] st, input logic lst);
        deq_word_t w;
        w.value  = v;
        w.status = st;
        w.last   = lst;
        owed_results.push_back(w);
        if (st == deq_pkg::ST_FULL) n_full++;
        if (st == deq_pkg::ST_EMPTY) n_empty++;
    endtask

    task automatic apply_operation(input logic [2:0] mode, input logic [31:0] v);
        int unsigned pos;
        case (mode)
            deq_pkg::MODE_PUSH_BACK, deq_pkg::MODE_PUSH_FRONT: begin
                if (depth_used == CAPACITY) begin
                    owe('0, deq_pkg::ST_FULL, 1'b1);
                end else begin
                    if (mode == deq_pkg::MODE_PUSH_BACK) begin
                        deque_mem[slot(depth_used)] = v;
                    end else begin
                        front_pos = slot(CAPACITY - 1);
                        deque_mem[front_pos] = v;
                    end
                    depth_used++;
                    owe('0, deq_pkg::ST_OK, 1'b1);
                end
            end
            deq_pkg::MODE_POP_BACK, deq_pkg::MODE_POP_FRONT: begin
                if (depth_used == 0) begin
                    owe('0, deq_pkg::ST_EMPTY, 1'b1);
                end else begin
                    if (mode == deq_pkg::MODE_POP_BACK) begin
                        pos = slot(depth_used - 1);
                    end else begin
                        pos = front_pos;
                        front_pos = slot(1);
                    end
                    depth_used--;
                    owe(deque_mem[pos], deq_pkg::ST_OK, 1'b1);
                end
            end
            deq_pkg::MODE_LIST: begin
                if (depth_used == 0) begin
                    owe('0, deq_pkg::ST_EMPTY, 1'b1);
                end else begin
                    for (int unsigned i = 0; i < depth_used; i++) begin
                        owe(deque_mem[slot(i)], deq_pkg::ST_OK, (i + 1 == depth_used));
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_result();
        deq_word_t w;
        n_out++;
        if (owed_results.size() == 0) begin
            $error("unexpected result word: value_res %0d status %0d last %0d",
                   $signed(m_tdata), m_tuser, m_tlast);
            errs++;
        end else begin
            w = owed_results.pop_front();
            if (m_tdata !== w.value) begin
                $error("value_res mismatch: expected %0d, got %0d",
                       $signed(w.value), $signed(m_tdata));
                errs++;
            end
            if (m_tuser !== w.status) begin
                $error("status mismatch: expected %0d, got %0d", w.status, m_tuser);
                errs++;
            end
            if (m_tlast !== w.last) begin
                $error("last mismatch: expected %0d, got %0d", w.last, m_tlast);
                errs++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            front_pos  = 0;
            depth_used = 0;
            owed_results.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                n_in++;
                apply_operation(s_tdata[2:0], s_tdata[34:3]);
            end
            if (m_tvalid && m_tready) begin
                check_result();
            end
        end
        error_count   <= errs;
        pending       <= owed_results.size();
        words_in      <= n_in;
        results_out   <= n_out;
        full_drops    <= n_full;
        empty_reports <= n_empty;
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the double-ended queue: clock, reset, stimulus, watchdog and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH           = 16;
    localparam int HOLD_CYCLES     = 300;
    localparam int STALL_LIMIT     = 4000;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int HOLD_ITEMS      = 24;
    localparam int SETTLE_CYCLES   = 24;

    localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int send_idle_pct = 37;
    int recv_idle_pct = 86;
    bit hold_req      = 1'b0;
    bit hold_done     = 1'b0;
    int quiet_cycles  = 0;

    int error_count;
    int pending;
    int words_in;
    int results_out;
    int full_drops;
    int empty_reports;

    always #4 aclk = ~aclk;

    double_ended_queue #(
        .CAPACITY(DEPTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    deque_checker #(
        .CAPACITY(DEPTH)
    ) u_chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .error_count  (error_count),
        .pending      (pending),
        .words_in     (words_in),
        .results_out  (results_out),
        .full_drops   (full_drops),
        .empty_reports(empty_reports)
    );

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_word(input logic [2:0] mode, input logic [31:0] val);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, val, mode};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [2:0] pick_push();
        return $urandom_range(1) ? deq_pkg::MODE_PUSH_BACK : deq_pkg::MODE_PUSH_FRONT;
    endfunction

    task automatic run_directed();
        send_word(deq_pkg::MODE_POP_BACK, $urandom());
        send_word(deq_pkg::MODE_POP_FRONT, $urandom());
        send_word(deq_pkg::MODE_LIST, $urandom());
        send_word(MODE_UNUSED_LO, $urandom());
        send_word(MODE_UNUSED_HI, $urandom());
        send_word(deq_pkg::MODE_PUSH_BACK, 32'h7FFF_FFFF);
        send_word(deq_pkg::MODE_PUSH_FRONT, 32'h8000_0000);
        for (int i = 0; i < DEPTH - 2; i++) begin
            send_word(pick_push(), pick_value());
        end
        send_word(deq_pkg::MODE_PUSH_FRONT, $urandom());
        send_word(deq_pkg::MODE_LIST, $urandom());
        send_word(deq_pkg::MODE_POP_BACK, $urandom());
        send_word(deq_pkg::MODE_POP_FRONT, $urandom());
    endtask

    task automatic run_random(input int count);
        int         done_ops;
        int         r;
        bit         fill_lean;
        logic [2:0] mode;
        done_ops  = 0;
        fill_lean = 1'b1;
        while (done_ops < count) begin
            if ($urandom_range(19) == 0) fill_lean = ~fill_lean;
            if ($urandom_range(59) == 0) drain();
            r = $urandom_range(99);
            if (r < 4) begin
                mode = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
            end else if (r < 12) begin
                mode = deq_pkg::MODE_LIST;
            end else if (r < (fill_lean ? 75 : 35)) begin
                mode = pick_push();
            end else begin
                mode = $urandom_range(1) ? deq_pkg::MODE_POP_BACK : deq_pkg::MODE_POP_FRONT;
            end
            send_word(mode, pick_value());
            if (mode <= deq_pkg::MODE_POP_FRONT) done_ops++;
        end
    endtask

    initial begin
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        aresetn  <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        run_random(ITEMS_PER_PHASE);
        drain();

        send_idle_pct = 86;
        recv_idle_pct = 37;
        run_random(ITEMS_PER_PHASE);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        run_random(HOLD_ITEMS);
        drain();
        run_random(ITEMS_PER_PHASE - HOLD_ITEMS);
        drain();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("tb: %0d words in, %0d result words checked, %0d full drops, %0d empty reports",
                 words_in, results_out, full_drops, empty_reports);
        $display("tb: covered three idling mixes and a %0d-cycle receiver hold-off",
                 HOLD_CYCLES);
        if (error_count == 0 && pending == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/deq_pkg.sv
rtl/deq_dp.sv
rtl/deq_ctrl.sv
rtl/double_ended_queue.sv
tb/deque_checker.sv
tb/tb.sv
